// File: src/insertion_sorter_assert.svh
// Assertion macros for the insertion sorter.
// Each check is sampled on the rising edge of clk and is off while rst_n is low.
`ifndef INSERTION_SORTER_ASSERT_SVH
`define INSERTION_SORTER_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define IS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("insertion_sorter check failed");

`define IS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("insertion_sorter check failed");

`else

`define IS_ASSERT_SAME(label, ante, cons)

`define IS_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// File: src/isort_pkg.sv
`default_nettype none

package isort_pkg;

    localparam int MAX_ITEMS = 32;
    localparam int VALUE_W   = 32;
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } state_t;

    // Per-cell control from the top level.
    typedef struct packed {
        logic insert;
        logic shift;
        logic occupied;
        logic tail;
    } cell_ctrl_t;

    // What a cell hands to its neighbors.
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      greater;
    } link_t;

endpackage

`default_nettype wire

// File: src/insertion_sorter.sv
// Latency: a word is placed in the sorted row at the clock edge that accepts it, unless the row is full.
// After the word marked last, results follow from the next cycle on, one per cycle,
// with no gaps, one for each stored entry; busy stays high while the row drains.
// Throughput: one word per cycle while loading; no word is taken while the row drains.
// The receiver cannot stall, so the drain never pauses.
// Reset clears the fill count, the overflow flag and the drain state; cell contents are kept.
`default_nettype none

module insertion_sorter
    import isort_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic signed [VALUE_W-1:0] value,
    input  wire logic                      last_in,
    output logic                           out_valid,
    output logic signed [VALUE_W-1:0]      sorted_value,
    output logic                           last_out,
    output logic                           overflow
);

    `include "insertion_sorter_assert.svh"

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;
    logic             dropped_reg;
    logic             dropped_next;

    logic             accept;
    logic             full;
    logic             do_insert;
    logic             do_shift;

    cell_ctrl_t       ctrl    [MAX_ITEMS];
    link_t            link    [MAX_ITEMS];
    link_t            left_in [MAX_ITEMS];
    logic signed [VALUE_W-1:0] right_in [MAX_ITEMS];

    assign accept    = start && (state_reg == ST_IDLE);
    assign full      = (fill_reg == CNT_W'(MAX_ITEMS));
    assign do_insert = accept && !full;
    assign do_shift  = (state_reg == ST_EMIT);

    always_comb
    begin
        state_next   = state_reg;
        fill_next    = fill_reg;
        dropped_next = dropped_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (full)
                    begin
                        dropped_next = 1'b1;
                    end
                    else
                    begin
                        fill_next = fill_reg + CNT_W'(1);
                    end
                    if (last_in)
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                // The fill count doubles as the number of words still to send.
                fill_next = fill_reg - CNT_W'(1);
                if (fill_reg == CNT_W'(1))
                begin
                    state_next   = ST_IDLE;
                    dropped_next = 1'b0;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            fill_reg    <= '0;
            dropped_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            dropped_reg <= dropped_next;
        end
    end

    genvar i;
    generate
        for (i = 0; i < MAX_ITEMS; i++)
        begin : g_cell
            assign ctrl[i].insert   = do_insert;
            assign ctrl[i].shift    = do_shift;
            assign ctrl[i].occupied = (CNT_W'(i) < fill_reg);
            assign ctrl[i].tail     = (CNT_W'(i) == fill_reg);

            if (i == 0)
            begin : g_head
                assign left_in[i] = '0;
            end
            else
            begin : g_body
                assign left_in[i] = link[i-1];
            end

            if (i == MAX_ITEMS - 1)
            begin : g_end
                assign right_in[i] = '0;
            end
            else
            begin : g_mid
                assign right_in[i] = link[i+1].value;
            end

            isort_cell u_cell (
                .clk         (clk),
                .ctrl        (ctrl[i]),
                .v           (value),
                .left        (left_in[i]),
                .right_value (right_in[i]),
                .link        (link[i])
            );
        end
    endgenerate

    assign busy         = (state_reg == ST_EMIT);
    assign out_valid    = (state_reg == ST_EMIT);
    assign sorted_value = link[0].value;
    assign last_out     = (state_reg == ST_EMIT) && (fill_reg == CNT_W'(1));
    assign overflow     = dropped_reg;

    `IS_ASSERT_SAME(a_fill_range, 1'b1, fill_reg <= CNT_W'(MAX_ITEMS))
    `IS_ASSERT_NEXT(a_drain_ends, last_out, !busy)
    `IS_ASSERT_NEXT(a_no_early_result, accept && !last_in, !out_valid)
    `IS_ASSERT_NEXT(a_no_gaps, out_valid && !last_out, out_valid)

endmodule

`default_nettype wire

// File: src/isort_cell.sv
`default_nettype none

module isort_cell
    import isort_pkg::*;
(
    input  wire logic                      clk,
    input  wire cell_ctrl_t                ctrl,
    input  wire logic signed [VALUE_W-1:0] v,
    input  wire link_t                     left,
    input  wire logic signed [VALUE_W-1:0] right_value,
    output link_t                          link
);

    logic signed [VALUE_W-1:0] value_reg;
    logic signed [VALUE_W-1:0] value_next;
    logic                      greater;

    // A stored entry strictly above the new word moves up, so equal words keep their order.
    assign greater = ctrl.occupied && (value_reg > v);

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.insert && (greater || ctrl.tail))
        begin
            value_next = left.greater ? left.value : v;
        end
        else if (ctrl.shift)
        begin
            value_next = right_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign link.value   = value_reg;
    assign link.greater = greater;

endmodule

`default_nettype wire

// File: dv/tb.sv
`default_nettype none

module tb
    import isort_pkg::*;
();

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_WORDS = 300;

    typedef struct {
        logic signed [VALUE_W-1:0] value;
        logic                      last;
        logic                      ovf;
    } sorted_word_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      start = 1'b0;
    logic signed [VALUE_W-1:0] value = '0;
    logic                      last_in = 1'b0;
    logic                      busy;
    logic                      out_valid;
    logic signed [VALUE_W-1:0] sorted_value;
    logic                      last_out;
    logic                      overflow;

    // Copy of the list the sorter should hold for the set being loaded.
    logic signed [VALUE_W-1:0] sort_row[$];
    logic                      row_dropped = 1'b0;
    sorted_word_t              pending_words[$];

    int error_count = 0;
    int cycle_count = 0;
    int sent_count  = 0;

    insertion_sorter dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .value        (value),
        .last_in      (last_in),
        .out_valid    (out_valid),
        .sorted_value (sorted_value),
        .last_out     (last_out),
        .overflow     (overflow)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Insert after every entry that is not greater, so equal values keep arrival order.
    function automatic void place_in_row(logic signed [VALUE_W-1:0] v);
        int pos;
        if (sort_row.size() >= MAX_ITEMS)
        begin
            row_dropped = 1'b1;
            return;
        end
        pos = sort_row.size();
        while (pos > 0 && sort_row[pos - 1] > v)
            pos--;
        sort_row.insert(pos, v);
    endfunction

    function automatic void emit_row();
        sorted_word_t w;
        foreach (sort_row[k])
        begin
            w.value = sort_row[k];
            w.last  = (k == sort_row.size() - 1);
            w.ovf   = row_dropped;
            pending_words.push_back(w);
        end
        sort_row.delete();
        row_dropped = 1'b0;
    endfunction

    function automatic int pick_gap(bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic signed [VALUE_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return $urandom;
        if (r < 9)
            return $signed(VALUE_W'($urandom_range(0, 6))) - 3;
        return ($urandom_range(0, 1) != 0) ? {1'b0, {(VALUE_W-1){1'b1}}}
                                           : {1'b1, {(VALUE_W-1){1'b0}}};
    endfunction

    task automatic send_word(input logic signed [VALUE_W-1:0] v, input logic l, input int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            value <= $urandom;
            last_in <= 1'($urandom_range(0, 1));
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        value   <= v;
        last_in <= l;
        do
            @(posedge clk);
        while (busy);
        place_in_row(v);
        if (l)
            emit_row();
        sent_count++;
    endtask

    task automatic sort_set(input int n, input bit quiet);
        for (int i = 0; i < n; i++)
            send_word(pick_value(), i == n - 1, pick_gap(quiet));
    endtask

    task automatic test_directed();
        send_word(0, 1'b1, 0);
        // Both ends of the range together with values around zero.
        send_word(32'sh7FFF_FFFF, 1'b0, 0);
        send_word(32'sh8000_0000, 1'b0, 0);
        send_word(-1, 1'b0, 0);
        send_word(0, 1'b0, 0);
        send_word(1, 1'b1, 0);
        send_word(40, 1'b0, 0);
        send_word(30, 1'b0, 1);
        send_word(20, 1'b0, 0);
        send_word(-10, 1'b1, 0);
        send_word(5, 1'b0, 0);
        send_word(5, 1'b0, 2);
        send_word(-3, 1'b0, 0);
        send_word(5, 1'b1, 0);
        send_word(-7, 1'b0, 0);
        send_word(-6, 1'b0, 0);
        send_word(8, 1'b0, 0);
        send_word(9, 1'b1, 0);
        send_word(32'sh7FFF_FFFF, 1'b1, 3);
    endtask

    task automatic test_overflow();
        // A full row, then one whose last word is dropped, then several dropped.
        sort_set(MAX_ITEMS, 1'b0);
        sort_set(MAX_ITEMS + 1, 1'b1);
        sort_set(MAX_ITEMS + 5, 1'b0);
    endtask

    task automatic test_random_sets();
        int goal;
        int n;
        goal = sent_count + RANDOM_WORDS - 3 * MAX_ITEMS;
        while (sent_count < goal)
        begin
            n = ($urandom_range(0, 19) == 0) ? $urandom_range(9, MAX_ITEMS + 3)
                                             : $urandom_range(1, 8);
            sort_set(n, $urandom_range(0, 3) == 0);
        end
    endtask

    always @(posedge clk)
    begin
        sorted_word_t w;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d words still expected", $time, pending_words.size());
            $display("FAIL");
            $finish;
        end
        if (rst_n && out_valid)
        begin
            if (pending_words.size() == 0)
            begin
                $display("%0t: unexpected word, expected none, got %0d", $time, sorted_value);
                error_count++;
            end
            else
            begin
                w = pending_words.pop_front();
                if (sorted_value !== w.value)
                begin
                    $display("%0t: sorted_value expected %0d got %0d",
                             $time, w.value, sorted_value);
                    error_count++;
                end
                if (last_out !== w.last)
                begin
                    $display("%0t: last_out expected %0b got %0b", $time, w.last, last_out);
                    error_count++;
                end
                if (overflow !== w.ovf)
                begin
                    $display("%0t: overflow expected %0b got %0b", $time, w.ovf, overflow);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_overflow();
        test_random_sets();
        start <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (pending_words.size() != 0)
        begin
            $display("%0t: %0d expected words never arrived", $time, pending_words.size());
            error_count++;
        end
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire
